// ===== rtl/brct_pkg.sv =====
// shared types, widths and codes for the byte range cell table
// used by brct_cell, brct_ctrl and byte_range_cell_table; no dependencies
package brct_pkg;

  localparam int unsigned OFF_W   = 13;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned BOUND_W = 14;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned DEF_TABLE_ENTRIES = 32;
  localparam int unsigned MAX_RESULTS       = 32;
  localparam int unsigned CNT_W             = $clog2(MAX_RESULTS);

  localparam int unsigned IN_DATA_W  = ((OFF_W + SIZE_W + 2 * BOUND_W + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OFF_W + SIZE_W + 7) / 8) * 8;

  // request codes
  localparam logic [ACT_W-1:0] ACT_MAKE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POINT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BOUND  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  typedef enum logic [2:0] {
    CO_HOLD,
    CO_EVAL,
    CO_INSERT,
    CO_REMOVE,
    CO_SKIP
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EXEC,
    S_REPORT
  } state_t;

  // one table entry; gmax is the largest size among entries sharing this offset
  typedef struct packed {
    logic              valid;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] gmax;
    logic              hit;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t           op;
    logic [ACT_W-1:0]   action;
    logic [OFF_W-1:0]   q_off;
    logic [SIZE_W-1:0]  q_size;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic [SIZE_W-1:0]  new_gmax;
    logic [OFF_W-1:0]   rm_off;
    logic [SIZE_W-1:0]  rm_size;
    logic [SIZE_W-1:0]  prev_size;
  } cell_cmd_t;

  // summary of the chain seen by the controller
  typedef struct packed {
    logic              any;
    logic              more;
    logic              full;
    logic [OFF_W-1:0]  sel_off;
    logic [SIZE_W-1:0] sel_size;
    logic [SIZE_W-1:0] grp_gmax;
    logic [SIZE_W-1:0] prev_size;
  } chain_stat_t;

endpackage

// ===== rtl/byte_range_cell_table.sv =====
// top level of the byte range cell table: a sorted chain of brct_cell
// instances and the brct_ctrl sequencer; uses brct_pkg
//
// channel  handshake              payload
// in       in_tvalid, in_tready   tuser action; tdata offset, size, low, high, remove
// out      out_tvalid, out_tready tuser status; tdata offset, size; tlast last
//
// a make, remove, lookup or unknown code steps through accept, a compare across all
// cells and a step that acts and loads the result before the next beat can be accepted
// an overlap query steps through accept and compare, then one result beat per cycle
// while the result register is free (at most 32), walking the hits along the chain
// the result register lets a beat wait on out_tready; a stall holds the sequencer
// synchronous reset empties the table at once through the cell valid bits
module byte_range_cell_table #(
  parameter int unsigned TABLE_ENTRIES = brct_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [12:0] query_offset, [25:13] query_size, [39:26] range_low,
  // [53:40] range_high, [54] remove_found, [55] zero
  input  logic [brct_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [brct_pkg::ACT_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [12:0] cell_offset, [25:13] cell_size, [31:26] zero
  output logic [brct_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [brct_pkg::STAT_W-1:0]     out_tuser,
  output logic                            out_tlast
);
  import brct_pkg::*;

  cell_cmd_t   cmd;
  chain_stat_t stat;

  entry_t cur  [TABLE_ENTRIES];
  entry_t view [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] lt_vec, eqoff_vec, valid_vec, hit_vec;
  logic [TABLE_ENTRIES-1:0] pre_vec, sel_vec, nb_vec;

  genvar i;
  generate
    for (i = 0; i < TABLE_ENTRIES; i++) begin : gen_chain
      entry_t lview, rview;
      logic   llt;

      assign valid_vec[i] = cur[i].valid;
      assign hit_vec[i]   = cur[i].hit;
      // set from the first hit onwards
      assign pre_vec[i]   = |hit_vec[i:0];

      if (i == 0) begin : gen_head
        assign lview      = '0;
        assign llt        = 1'b1;
        assign sel_vec[i] = hit_vec[i];
      end else begin : gen_body
        assign lview      = view[i-1];
        assign llt        = lt_vec[i-1];
        assign sel_vec[i] = hit_vec[i] && !pre_vec[i-1];
      end

      if (i == TABLE_ENTRIES - 1) begin : gen_tail
        assign rview     = '0;
        assign nb_vec[i] = 1'b0;
      end else begin : gen_inner
        assign rview     = view[i+1];
        // predecessor of the removed cell within the same offset group
        assign nb_vec[i] = sel_vec[i+1] && cur[i].valid && (cur[i].off == cur[i+1].off);
      end

      brct_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .left_view  (lview),
        .left_lt    (llt),
        .right_view (rview),
        .pre        (pre_vec[i]),
        .sel        (sel_vec[i]),
        .cur_o      (cur[i]),
        .view_o     (view[i]),
        .lt_o       (lt_vec[i]),
        .eqoff_o    (eqoff_vec[i])
      );
    end
  endgenerate

  // one-hot selects onto shared buses; grp_gmax ORs the cells of one offset group, which share one gmax
  always_comb begin
    stat.any       = |hit_vec;
    stat.more      = |(hit_vec & ~sel_vec);
    stat.full      = valid_vec[TABLE_ENTRIES-1];
    stat.sel_off   = '0;
    stat.sel_size  = '0;
    stat.grp_gmax  = '0;
    stat.prev_size = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      stat.sel_off   = stat.sel_off   | ({OFF_W{sel_vec[k]}}    & cur[k].off);
      stat.sel_size  = stat.sel_size  | ({SIZE_W{sel_vec[k]}}   & cur[k].size);
      stat.grp_gmax  = stat.grp_gmax  | ({SIZE_W{eqoff_vec[k]}} & cur[k].gmax);
      stat.prev_size = stat.prev_size | ({SIZE_W{nb_vec[k]}}    & cur[k].size);
    end
  end

  brct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .stat       (stat),
    .cmd        (cmd)
  );

  // occupied cells stay packed at the low end of the chain
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("gap in the entry chain");

  a_hit_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_vec & ~valid_vec) == '0)
    else $error("hit flag on an empty cell");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one cell selected");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CO_REMOVE) |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
    else $error("remove did not free exactly one cell");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CO_INSERT) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("insert did not fill exactly one cell");

endmodule

// ===== rtl/brct_cell.sv =====
// one cell of the sorted entry chain: holds an entry, compares it with the
// broadcast request and shifts to or from its neighbours; uses brct_pkg
module brct_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  brct_pkg::cell_cmd_t cmd,
  input  brct_pkg::entry_t    left_view,
  input  logic                left_lt,
  input  brct_pkg::entry_t    right_view,
  input  logic                pre,
  input  logic                sel,
  output brct_pkg::entry_t    cur_o,
  output brct_pkg::entry_t    view_o,
  output logic                lt_o,
  output logic                eqoff_o
);
  import brct_pkg::*;

  entry_t cur_r, cur_nxt;
  entry_t view;
  entry_t new_ent;
  logic   lt_r, lt_nxt;
  logic   eqoff_r, eqoff_nxt;

  logic [BOUND_W-1:0] q_end, c_end, g_end;
  logic               eq, pt, bd, hit_eval, lt_eval, eqoff_eval;

  // per-cell compares against the request
  always_comb begin
    q_end = BOUND_W'(cmd.q_off) + BOUND_W'(cmd.q_size);
    c_end = BOUND_W'(cur_r.off) + BOUND_W'(cur_r.size);
    g_end = BOUND_W'(cur_r.off) + BOUND_W'(cur_r.gmax);
    eq    = (cur_r.off == cmd.q_off) && (cur_r.size == cmd.q_size);
    pt    = (BOUND_W'(cur_r.off) < q_end) && (BOUND_W'(cmd.q_off) < c_end) && !eq;
    // group end reaches lo is the same as x + gmax - 1 >= lo
    bd    = (cmd.lo <= cmd.hi) && (cur_r.gmax != '0) &&
            (BOUND_W'(cur_r.off) <= cmd.hi) && (g_end > cmd.lo);
    unique case (cmd.action)
      ACT_MAKE, ACT_REMOVE, ACT_LOOKUP: hit_eval = cur_r.valid && eq;
      ACT_POINT:                        hit_eval = cur_r.valid && pt;
      ACT_BOUND:                        hit_eval = cur_r.valid && bd;
      default:                          hit_eval = 1'b0;
    endcase
    lt_eval    = cur_r.valid && ({cur_r.off, cur_r.size} < {cmd.q_off, cmd.q_size});
    eqoff_eval = cur_r.valid && (cur_r.off == cmd.q_off);
  end

  // entry as handed to neighbours, with the group maximum brought up to date
  always_comb begin
    view = cur_r;
    unique case (cmd.op)
      CO_INSERT: begin
        if (eqoff_r) view.gmax = cmd.new_gmax;
      end
      CO_REMOVE: begin
        if (cur_r.valid && (cur_r.off == cmd.rm_off) && (cur_r.gmax == cmd.rm_size))
          view.gmax = cmd.prev_size;
      end
      default: ;
    endcase
  end

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.off   = cmd.q_off;
    new_ent.size  = cmd.q_size;
    new_ent.gmax  = cmd.new_gmax;
    new_ent.hit   = 1'b0;
  end

  always_comb begin
    cur_nxt   = cur_r;
    lt_nxt    = lt_r;
    eqoff_nxt = eqoff_r;
    unique case (cmd.op)
      CO_EVAL: begin
        cur_nxt.hit = hit_eval;
        lt_nxt      = lt_eval;
        eqoff_nxt   = eqoff_eval;
      end
      CO_INSERT: begin
        // cells below the new key stay, the first one above takes the new entry, the rest take their left neighbour
        if (lt_r) cur_nxt = view;
        else if (left_lt) cur_nxt = new_ent;
        else cur_nxt = left_view;
      end
      CO_REMOVE: begin
        cur_nxt = pre ? right_view : view;
      end
      CO_SKIP: begin
        if (sel) cur_nxt.hit = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
      cur_r.hit   <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lt_r    <= lt_nxt;
    eqoff_r <= eqoff_nxt;
  end

  assign cur_o   = cur_r;
  assign view_o  = view;
  assign lt_o    = lt_r;
  assign eqoff_o = eqoff_r;

endmodule

// ===== rtl/brct_ctrl.sv =====
// request sequencer: takes request beats, drives the cell chain and holds
// the result register; uses brct_pkg
module brct_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [brct_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [brct_pkg::ACT_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brct_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [brct_pkg::STAT_W-1:0]       out_tuser,
  output logic                              out_tlast,
  input  brct_pkg::chain_stat_t             stat,
  output brct_pkg::cell_cmd_t               cmd
);
  import brct_pkg::*;

  localparam int unsigned SIZE_LSB = OFF_W;
  localparam int unsigned LO_LSB   = OFF_W + SIZE_W;
  localparam int unsigned HI_LSB   = LO_LSB + BOUND_W;
  localparam int unsigned RM_BIT   = HI_LSB + BOUND_W;
  localparam int unsigned PAD_W    = OUT_DATA_W - OFF_W - SIZE_W;

  state_t state_r, state_nxt;

  logic [ACT_W-1:0]   act_r;
  logic [OFF_W-1:0]   q_off_r;
  logic [SIZE_W-1:0]  q_size_r;
  logic [BOUND_W-1:0] lo_r, hi_r;
  logic               rm_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [OFF_W-1:0]   out_off_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic               out_last_r;

  logic               accept, out_free, rep_last, out_load;
  logic [STAT_W-1:0]  ld_status;
  logic [OFF_W-1:0]   ld_off;
  logic [SIZE_W-1:0]  ld_size;
  logic               ld_last;
  logic [SIZE_W-1:0]  new_gmax;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign rep_last = !stat.more || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign new_gmax = (stat.grp_gmax > q_size_r) ? stat.grp_gmax : q_size_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act_r == ACT_POINT || act_r == ACT_BOUND) state_nxt = S_REPORT;
        else state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_REPORT: begin
        if (out_free && (!stat.any || rep_last)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: chain command and result load
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.op        = CO_HOLD;
    cmd.action    = act_r;
    cmd.q_off     = q_off_r;
    cmd.q_size    = q_size_r;
    cmd.lo        = lo_r;
    cmd.hi        = hi_r;
    cmd.new_gmax  = new_gmax;
    cmd.rm_off    = stat.sel_off;
    cmd.rm_size   = stat.sel_size;
    cmd.prev_size = stat.prev_size;
    out_load      = 1'b0;
    ld_status     = STAT_NONE;
    ld_off        = '0;
    ld_size       = '0;
    ld_last       = 1'b1;
    unique case (state_r)
      S_IDLE: ;
      S_EVAL: cmd.op = CO_EVAL;
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (act_r)
            ACT_MAKE: begin
              if (stat.any) begin
                ld_status = STAT_HIT;
                ld_off    = q_off_r;
                ld_size   = q_size_r;
              end else if (stat.full) begin
                ld_status = STAT_FULL;
              end else begin
                cmd.op    = CO_INSERT;
                ld_status = STAT_OK;
                ld_off    = q_off_r;
                ld_size   = q_size_r;
              end
            end
            ACT_REMOVE: begin
              if (stat.any) begin
                cmd.op    = CO_REMOVE;
                ld_status = STAT_OK;
                ld_off    = q_off_r;
                ld_size   = q_size_r;
              end
            end
            ACT_LOOKUP: begin
              if (stat.any) begin
                ld_status = STAT_HIT;
                ld_off    = q_off_r;
                ld_size   = q_size_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (stat.any) begin
            ld_status = rm_r ? STAT_OK : STAT_HIT;
            ld_off    = stat.sel_off;
            ld_size   = stat.sel_size;
            ld_last   = rep_last;
            cmd.op    = rm_r ? CO_REMOVE : CO_SKIP;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) cnt_r <= '0;
      else if (state_r == S_REPORT && out_load) cnt_r <= cnt_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tuser;
      q_off_r  <= in_tdata[SIZE_LSB-1:0];
      q_size_r <= in_tdata[LO_LSB-1:SIZE_LSB];
      lo_r     <= in_tdata[HI_LSB-1:LO_LSB];
      hi_r     <= in_tdata[RM_BIT-1:HI_LSB];
      rm_r     <= in_tdata[RM_BIT];
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_off_r    <= ld_off;
      out_size_r   <= ld_size;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_size_r, out_off_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for byte_range_cell_table: directed and random requests,
// a behavioural model of the cell table predicts every result beat in order
// depends on brct_pkg and the rtl of byte_range_cell_table
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brct_pkg::*;

  localparam int unsigned NUM_SLOTS  = DEF_TABLE_ENTRIES;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned TAIL_WAIT  = 80;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned OFF_TOP    = (1 << OFF_W) - 1;
  localparam int unsigned SIZE_TOP   = (1 << SIZE_W) - 1;
  localparam int unsigned BOUND_TOP  = (1 << BOUND_W) - 1;
  localparam int unsigned ACT_TOP    = (1 << ACT_W) - 1;
  localparam int unsigned SPACE_TOP  = 4096;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [OFF_W-1:0]   q_off;
    logic [SIZE_W-1:0]  q_size;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic               remove_found;
  } table_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
    logic              last;
  } table_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [12:0] query_offset, [25:13] query_size, [39:26] range_low,
  // [53:40] range_high, [54] remove_found, [55] zero
  logic [IN_DATA_W-1:0]  in_tdata;
  // [2:0] action
  logic [ACT_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // [12:0] cell_offset, [25:13] cell_size, [31:26] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // [1:0] status
  logic [STAT_W-1:0]     out_tuser;
  logic                  out_tlast;

  byte_range_cell_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow copy of the cell table
  bit                cell_used [NUM_SLOTS];
  logic [OFF_W-1:0]  cell_off  [NUM_SLOTS];
  logic [SIZE_W-1:0] cell_len  [NUM_SLOTS];

  table_beat_t   pending_beats[$];
  int unsigned   mismatches;
  int unsigned   cycles;
  bit            steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void push_beat(input logic [STAT_W-1:0] st, input logic [OFF_W-1:0] off,
                                    input logic [SIZE_W-1:0] sz, input logic last);
    table_beat_t b;
    b.status = st;
    b.off    = off;
    b.size   = sz;
    b.last   = last;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  // works out the result beats of one accepted request and updates the shadow table
  function automatic void predict_request(input table_req_t r);
    int          found;
    int          slot;
    int          listed[$];
    int          n;
    int          j;
    bit          m;
    int unsigned a, b, big;
    found = -1;
    for (int i = NUM_SLOTS - 1; i >= 0; i--)
      if (cell_used[i] && cell_off[i] == r.q_off && cell_len[i] == r.q_size) found = i;
    if (r.action == ACT_MAKE) begin
      if (found >= 0) begin
        push_beat(STAT_HIT, r.q_off, r.q_size, 1'b1);
      end else begin
        slot = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
          if (!cell_used[i]) slot = i;
        if (slot >= 0) begin
          cell_used[slot] = 1'b1;
          cell_off[slot]  = r.q_off;
          cell_len[slot]  = r.q_size;
          push_beat(STAT_OK, r.q_off, r.q_size, 1'b1);
        end else begin
          push_beat(STAT_FULL, '0, '0, 1'b1);
        end
      end
    end else if (r.action == ACT_REMOVE || r.action == ACT_LOOKUP) begin
      if (found < 0) begin
        push_beat(STAT_NONE, '0, '0, 1'b1);
      end else if (r.action == ACT_REMOVE) begin
        cell_used[found] = 1'b0;
        push_beat(STAT_OK, r.q_off, r.q_size, 1'b1);
      end else begin
        push_beat(STAT_HIT, r.q_off, r.q_size, 1'b1);
      end
    end else if (r.action != ACT_POINT && r.action != ACT_BOUND) begin
      push_beat(STAT_NONE, '0, '0, 1'b1);
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!cell_used[i]) continue;
        if (r.action == ACT_POINT) begin
          m = (cell_off[i] < r.q_off + 32'(r.q_size)) && (r.q_off < cell_off[i] + 32'(cell_len[i]))
              && !(cell_off[i] == r.q_off && cell_len[i] == r.q_size);
        end else begin
          // whole offset group judged by its largest cell
          big = 0;
          for (int k = 0; k < NUM_SLOTS; k++)
            if (cell_used[k] && cell_off[k] == cell_off[i] && cell_len[k] > big) big = cell_len[k];
          if (big == 0 || r.lo > r.hi) begin
            m = 1'b0;
          end else begin
            a = (cell_off[i] > r.lo) ? cell_off[i] : r.lo;
            b = cell_off[i] + big - 1;
            if (b > r.hi) b = r.hi;
            m = (a <= b);
          end
        end
        if (m) begin
          j = 0;
          while (j < listed.size() &&
                 {cell_off[listed[j]], cell_len[listed[j]]} < {cell_off[i], cell_len[i]}) j++;
          listed.insert(j, i);
        end
      end
      if (listed.size() == 0) begin
        push_beat(STAT_NONE, '0, '0, 1'b1);
      end else begin
        n = (listed.size() > MAX_RESULTS) ? MAX_RESULTS : listed.size();
        for (int k = 0; k < n; k++) begin
          push_beat(r.remove_found ? STAT_OK : STAT_HIT, cell_off[listed[k]], cell_len[listed[k]],
                    k == n - 1);
          if (r.remove_found) cell_used[listed[k]] = 1'b0;
        end
      end
    end
  endfunction

  // result beat checker
  always @(posedge clk) begin : check_results
    table_beat_t got;
    table_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.off    = out_tdata[OFF_W-1:0];
      got.size   = out_tdata[OFF_W+SIZE_W-1:OFF_W];
      got.last   = out_tlast;
      if (pending_beats.size() == 0) begin
        if (mismatches < MAX_REPORT)
          $display("%0t: unexpected beat status %0d off %0d size %0d last %0d", $realtime,
                   got.status, got.off, got.size, got.last);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (got != want || out_tdata[OUT_DATA_W-1:OFF_W+SIZE_W] != '0) begin
          if (mismatches < MAX_REPORT)
            $display("%0t: exp st %0d off %0d size %0d last %0d, got %0d %0d %0d %0d (%h)",
                     $realtime, want.status, want.off, want.size, want.last,
                     got.status, got.off, got.size, got.last, out_tdata);
          mismatches++;
        end
      end
    end
  end

  function automatic table_req_t make_req(input int act, input int off, input int sz,
                                          input int lo, input int hi, input int rm);
    table_req_t r;
    r.action       = ACT_W'(act);
    r.q_off        = OFF_W'(off);
    r.q_size       = SIZE_W'(sz);
    r.lo           = BOUND_W'(lo);
    r.hi           = BOUND_W'(hi);
    r.remove_found = rm[0];
    return r;
  endfunction

  // one request beat; the model is updated at the accepting edge
  task automatic send_request(input table_req_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({r.remove_found, r.hi, r.lo, r.q_size, r.q_off});
    in_tuser  <= r.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(r);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OFF_W-1:0] pick_offset();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return OFF_W'($urandom_range(0, 15) * 8 + $urandom_range(0, 7));
    if (roll < 95) return OFF_W'($urandom_range(0, SPACE_TOP));
    return OFF_W'($urandom_range(0, OFF_TOP));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SIZE_W'($urandom_range(1, 32));
    if (roll < 85) return SIZE_W'($urandom_range(1, 512));
    if (roll < 95) return SIZE_W'($urandom_range(1, SPACE_TOP));
    return SIZE_W'($urandom_range(0, SIZE_TOP));
  endfunction

  function automatic table_req_t random_request();
    table_req_t r;
    int roll;
    int k;
    roll           = $urandom_range(0, 99);
    r.q_off        = pick_offset();
    r.q_size       = pick_size();
    r.remove_found = ($urandom_range(0, 3) == 0);
    if (roll < 35)      r.action = ACT_MAKE;
    else if (roll < 50) r.action = ACT_REMOVE;
    else if (roll < 63) r.action = ACT_LOOKUP;
    else if (roll < 80) r.action = ACT_POINT;
    else if (roll < 96) r.action = ACT_BOUND;
    else                r.action = ACT_W'($urandom_range(int'(ACT_BOUND) + 1, ACT_TOP));
    // removes and lookups mostly aim at a cell that exists
    if ((r.action == ACT_REMOVE || r.action == ACT_LOOKUP || r.action == ACT_MAKE)
        && $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, NUM_SLOTS - 1);
      if (cell_used[k] && (r.action != ACT_MAKE || $urandom_range(0, 2) == 0)) begin
        r.q_off  = cell_off[k];
        r.q_size = cell_len[k];
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      r.lo = BOUND_W'(pick_offset() + $urandom_range(0, 63));
      r.hi = r.lo + BOUND_W'($urandom_range(0, 255));
    end else if (roll < 95) begin
      r.lo = BOUND_W'($urandom_range(0, BOUND_TOP));
      r.hi = BOUND_W'($urandom_range(0, BOUND_TOP));
    end else begin
      r.lo = '0;
      r.hi = BOUND_W'(BOUND_TOP);
    end
    return r;
  endfunction

  task automatic test_basic_ops();
    send_request(make_req(ACT_MAKE, 0, 1, 0, 0, 0));
    send_request(make_req(ACT_MAKE, 0, 1, 0, 0, 0));
    send_request(make_req(ACT_LOOKUP, 0, 1, 0, 0, 0));
    send_request(make_req(ACT_LOOKUP, 0, 2, 0, 0, 0));
    send_request(make_req(ACT_REMOVE, 0, 2, 0, 0, 0));
    send_request(make_req(ACT_REMOVE, 0, 1, 0, 0, 0));
    send_request(make_req(ACT_LOOKUP, 0, 1, 0, 0, 0));
    // codes past the bound query do nothing
    for (int a = int'(ACT_BOUND) + 1; a <= ACT_TOP; a++)
      send_request(make_req(a, OFF_TOP, SIZE_TOP, BOUND_TOP, BOUND_TOP, 1));
  endtask

  task automatic test_overlap_edges();
    send_request(make_req(ACT_MAKE, SPACE_TOP, SPACE_TOP, 0, 0, 0));
    send_request(make_req(ACT_MAKE, OFF_TOP, SIZE_TOP, 0, 0, 0));
    send_request(make_req(ACT_MAKE, 0, SIZE_TOP, 0, 0, 0));
    send_request(make_req(ACT_MAKE, 100, 50, 0, 0, 0));
    send_request(make_req(ACT_MAKE, 100, 10, 0, 0, 0));
    send_request(make_req(ACT_MAKE, 150, 1, 0, 0, 0));
    // the exact query cell is left out of a point query
    send_request(make_req(ACT_POINT, 100, 10, 0, 0, 0));
    // zero-length point range
    send_request(make_req(ACT_POINT, 120, 0, 0, 0, 0));
    send_request(make_req(ACT_POINT, 0, 0, 0, 0, 0));
    // inverted bound range meets nothing
    send_request(make_req(ACT_BOUND, 0, 0, 200, 10, 1));
    // small cell at offset 100 reported through its group's largest size
    send_request(make_req(ACT_BOUND, 0, 0, 149, 149, 0));
    send_request(make_req(ACT_BOUND, 0, 0, BOUND_TOP, BOUND_TOP, 0));
    send_request(make_req(ACT_BOUND, 0, 0, 0, BOUND_TOP, 1));
    send_request(make_req(ACT_POINT, 0, SIZE_TOP, 0, 0, 1));
  endtask

  task automatic test_table_full();
    int k;
    for (int i = 0; i <= NUM_SLOTS; i++)
      send_request(make_req(ACT_MAKE, i * 128 + $urandom_range(0, 127), $urandom_range(1, 300),
                            0, 0, 0));
    k = $urandom_range(0, NUM_SLOTS - 1);
    send_request(make_req(ACT_MAKE, cell_off[k], cell_len[k], 0, 0, 0));
    send_request(make_req(ACT_POINT, 0, SIZE_TOP, 0, 0, 0));
    send_request(make_req(ACT_BOUND, 0, 0, 0, BOUND_TOP, 1));
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_request(random_request());
  endtask

  initial begin
    mismatches = 0;
    steady     = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cell_used[i] = 1'b0;
      cell_off[i]  = '0;
      cell_len[i]  = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    wait_drain();
    test_overlap_edges();
    wait_drain();
    test_table_full();
    wait_drain();
    test_random(320);
    wait_drain();
    // closing stretch with no idling on either side
    steady = 1'b1;
    test_random(70);
    wait_drain();
    repeat (TAIL_WAIT) @(posedge clk);

    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
